[hdl/elwr_pkg.sv]
// ----------------------------------------------------------------------------
// elwr_pkg: shared types and constants for the walk reachability core
// Function codes, stream field layout, controller states and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package elwr_pkg;

  // function codes carried on s_tuser
  localparam logic [1:0] FUNC_NEW_GRAPH = 2'd0;
  localparam logic [1:0] FUNC_ADD_EDGE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY     = 2'd2;

  // field widths
  localparam int FUNC_W  = 2;
  localparam int NODE_W  = 8;
  localparam int STEPS_W = 16;

  // stream widths and field positions inside s_tdata
  localparam int S_DATA_W  = 40;
  localparam int S_USER_W  = FUNC_W;
  localparam int M_DATA_W  = 8;
  localparam int COUNT_LSB = 0;
  localparam int NA_LSB    = 8;
  localparam int NB_LSB    = 16;
  localparam int STEPS_LSB = 24;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EDGE_RD_A,
    ST_EDGE_WR_A,
    ST_EDGE_RD_B,
    ST_EDGE_WR_B,
    ST_STEP_START,
    ST_SWEEP,
    ST_DRAIN,
    ST_STEP_END,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take;         // input transaction accepted this cycle
    logic clr_write;    // zero one adjacency row, advance row counter
    logic edge_rd_a;    // read row of first endpoint
    logic edge_wr_a;    // write row of first endpoint
    logic edge_rd_b;    // read row of second endpoint
    logic edge_wr_b;    // write row of second endpoint
    logic step_start;   // shift frontier history, clear accumulator
    logic sweep_issue;  // read adjacency row k, advance k
    logic step_end;     // commit next frontier
    logic out_load;     // load result register
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] in_func;
    logic       in_count_zero;
    logic       in_steps_zero;
    logic       clr_last;
    logic       sweep_last;
    logic       sweep_empty;
    logic       walk_done;
    logic       out_busy;
  } dp_status_t;

endpackage

[hdl/elwr_dp.sv]
// ----------------------------------------------------------------------------
// elwr_dp: datapath of the walk reachability core
// Adjacency row memory, frontier history registers, row sweep counter, step
// counter, period check and the result register.
// ----------------------------------------------------------------------------
module elwr_dp
  import elwr_pkg::*;
#(
  parameter int NODES = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_cmd_t           cmd,
  output dp_status_t          status,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [S_USER_W-1:0] s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);
  localparam int CMP_W = (CNT_W > NODE_W) ? CNT_W : NODE_W;

  // input field decode
  logic [NODE_W-1:0]  in_count;
  logic [NODE_W-1:0]  in_na;
  logic [NODE_W-1:0]  in_nb;
  logic [STEPS_W-1:0] in_steps;
  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   na_ext;
  logic [CMP_W-1:0]   nb_ext;
  logic [CMP_W-1:0]   used_ext;
  logic [CMP_W-1:0]   na_m1;
  logic [CMP_W-1:0]   nb_m1;
  logic [CMP_W-1:0]   count_sat;
  logic               in_a_ok;
  logic               in_b_ok;

  // held item
  logic [CNT_W-1:0]   nodes_in_use;
  logic [NODE_W-1:0]  na_q;
  logic [NODE_W-1:0]  nb_q;
  logic [STEPS_W-1:0] steps_q;
  logic [IDX_W-1:0]   a_idx;
  logic [IDX_W-1:0]   b_idx;
  logic               a_ok;
  logic               b_ok;

  // walk state
  logic [NODES-1:0]   frontier;
  logic [NODES-1:0]   old;
  logic [NODES-1:0]   older;
  logic [NODES-1:0]   acc;
  logic [STEPS_W-1:0] step_cnt;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   k_plus;
  logic               rd_pend;
  logic               rd_bit;
  logic               period;
  logic               odd_left;

  // memory
  logic [NODES-1:0]   adj [NODES];
  logic [NODES-1:0]   rdata;
  logic               rd_en;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [NODES-1:0]   wdata;

  // result
  logic               out_valid;
  logic               out_bit;
  logic               result;

  assign in_count = s_tdata[COUNT_LSB +: NODE_W];
  assign in_na    = s_tdata[NA_LSB +: NODE_W];
  assign in_nb    = s_tdata[NB_LSB +: NODE_W];
  assign in_steps = s_tdata[STEPS_LSB +: STEPS_W];

  // range checks against the node count in use
  assign count_ext = CMP_W'(in_count);
  assign na_ext    = CMP_W'(in_na);
  assign nb_ext    = CMP_W'(in_nb);
  assign used_ext  = CMP_W'(nodes_in_use);
  assign na_m1     = na_ext - CMP_W'(1);
  assign nb_m1     = nb_ext - CMP_W'(1);
  assign in_a_ok   = (in_na != '0) && (na_ext <= used_ext);
  assign in_b_ok   = (in_nb != '0) && (nb_ext <= used_ext);
  assign count_sat = (count_ext > CMP_W'(NODES)) ? CMP_W'(NODES) : count_ext;

  // period check and next-step parity
  assign k_plus   = k + CNT_W'(1);
  assign period   = (step_cnt != STEPS_W'(1)) && (acc == older);
  assign odd_left = steps_q[0] ^ step_cnt[0];
  assign result   = (steps_q == '0) ? (na_q == nb_q) : (a_ok && b_ok && frontier[b_idx]);

  // status to the controller
  always_comb begin
    status.in_func       = s_tuser;
    status.in_count_zero = (in_count == '0);
    status.in_steps_zero = (in_steps == '0);
    status.clr_last      = (k_plus == nodes_in_use);
    status.sweep_last    = (k_plus == nodes_in_use);
    status.sweep_empty   = (nodes_in_use == '0);
    status.walk_done     = period || (step_cnt == steps_q);
    status.out_busy      = out_valid && !m_tready;
  end

  // memory port selection
  always_comb begin
    rd_en = cmd.sweep_issue || ((cmd.edge_rd_a || cmd.edge_rd_b) && a_ok && b_ok);
    priority if (cmd.edge_rd_a) begin
      raddr = a_idx;
    end else if (cmd.edge_rd_b) begin
      raddr = b_idx;
    end else begin
      raddr = k[IDX_W-1:0];
    end
    we = cmd.clr_write || ((cmd.edge_wr_a || cmd.edge_wr_b) && a_ok && b_ok);
    priority if (cmd.clr_write) begin
      waddr = k[IDX_W-1:0];
      wdata = '0;
    end else if (cmd.edge_wr_a) begin
      waddr = a_idx;
      wdata = rdata | (NODES'(1) << b_idx);
    end else begin
      waddr = b_idx;
      wdata = rdata | (NODES'(1) << a_idx);
    end
  end

  // adjacency row memory
  always_ff @(posedge clk) begin
    if (we) begin
      adj[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= adj[raddr];
    end
  end

  // node count and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_in_use <= '0;
      k            <= '0;
      rd_pend      <= 1'b0;
    end else begin
      rd_pend <= cmd.sweep_issue;
      if (cmd.take && (s_tuser == FUNC_NEW_GRAPH)) begin
        nodes_in_use <= CNT_W'(count_sat);
        k            <= '0;
      end else if (cmd.step_start) begin
        k <= '0;
      end else if (cmd.clr_write || cmd.sweep_issue) begin
        k <= k_plus;
      end
    end
  end

  // captured item fields
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      na_q    <= in_na;
      nb_q    <= in_nb;
      steps_q <= in_steps;
      a_ok    <= in_a_ok;
      b_ok    <= in_b_ok;
      a_idx   <= na_m1[IDX_W-1:0];
      b_idx   <= nb_m1[IDX_W-1:0];
    end
  end

  // frontier history and accumulation
  always_ff @(posedge clk) begin
    if (cmd.sweep_issue) begin
      rd_bit <= frontier[k[IDX_W-1:0]];
    end
    if (cmd.take && (s_tuser == FUNC_QUERY)) begin
      frontier <= in_a_ok ? (NODES'(1) << na_m1[IDX_W-1:0]) : '0;
      old      <= '0;
      older    <= '0;
      step_cnt <= STEPS_W'(1);
    end else if (cmd.step_start) begin
      older <= old;
      old   <= frontier;
    end else if (cmd.step_end) begin
      frontier <= (period && odd_left) ? old : acc;
      step_cnt <= step_cnt + STEPS_W'(1);
    end
    if (cmd.step_start) begin
      acc <= '0;
    end else if (rd_pend && rd_bit) begin
      acc <= acc | rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_bit <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_DATA_W'(out_bit);

`ifndef SYNTH
  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_issue |-> (k < nodes_in_use))
    else $error("row sweep beyond node count");

  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without load");
`endif

endmodule

[hdl/elwr_ctrl.sv]
// ----------------------------------------------------------------------------
// elwr_ctrl: controller of the walk reachability core
// Sequences row clearing, edge read-modify-write and the step loop of a walk
// query, and loads the result once the output register is free.
// ----------------------------------------------------------------------------
module elwr_ctrl
  import elwr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   take;

  assign take = s_tvalid && s_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          unique case (status.in_func)
            FUNC_NEW_GRAPH: state_next = status.in_count_zero ? ST_IDLE : ST_CLEAR;
            FUNC_ADD_EDGE:  state_next = ST_EDGE_RD_A;
            FUNC_QUERY:     state_next = status.in_steps_zero ? ST_FINISH : ST_STEP_START;
            default:        state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_EDGE_RD_A:  state_next = ST_EDGE_WR_A;
      ST_EDGE_WR_A:  state_next = ST_EDGE_RD_B;
      ST_EDGE_RD_B:  state_next = ST_EDGE_WR_B;
      ST_EDGE_WR_B:  state_next = ST_IDLE;
      ST_STEP_START: state_next = status.sweep_empty ? ST_STEP_END : ST_SWEEP;
      ST_SWEEP: begin
        if (status.sweep_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:      state_next = ST_STEP_END;
      ST_STEP_END:   state_next = status.walk_done ? ST_FINISH : ST_STEP_START;
      ST_FINISH: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready        = (state == ST_IDLE);
    cmd             = '0;
    cmd.take        = take;
    cmd.clr_write   = (state == ST_CLEAR);
    cmd.edge_rd_a   = (state == ST_EDGE_RD_A);
    cmd.edge_wr_a   = (state == ST_EDGE_WR_A);
    cmd.edge_rd_b   = (state == ST_EDGE_RD_B);
    cmd.edge_wr_b   = (state == ST_EDGE_WR_B);
    cmd.step_start  = (state == ST_STEP_START);
    cmd.sweep_issue = (state == ST_SWEEP);
    cmd.step_end    = (state == ST_STEP_END);
    cmd.out_load    = (state == ST_FINISH) && !status.out_busy;
  end

`ifndef SYNTH
  a_zero_step_query: assert property (@(posedge clk) disable iff (rst)
    (take && (status.in_func == FUNC_QUERY) && status.in_steps_zero)
      |=> (state == ST_FINISH))
    else $error("zero step query did not go to finish");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_busy)
    else $error("result loaded over a held result");
`endif

endmodule

[hdl/exact_length_walk_reachability_core.sv]
// ----------------------------------------------------------------------------
// exact_length_walk_reachability_core: exact-length walk reachability
// Undirected graph held as a bit adjacency matrix; a query reports whether the
// end node lies in the frontier after exactly the given number of steps.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser: func; s_tdata: count, a, b, steps
// m_*      out  m_tvalid/m_tready  m_tdata: reachable
//
// new graph: one adjacency row cleared per cycle
// add edge: two row read-modify-writes through one memory port
// query: each step sweeps the adjacency rows, one row per cycle, into the
//   accumulator and commits the next frontier; with no node in use the sweep
//   is skipped; the walk stops early once it is periodic
// reset is synchronous and needs no clearing pass; the result register lets
//   the next item in while a result waits on m_tready
// ----------------------------------------------------------------------------
module exact_length_walk_reachability_core
  import elwr_pkg::*;
#(
  parameter int NODES = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // node_count[7:0], node_a[15:8], node_b[23:16],
                                         // steps[39:24]
  input  logic [S_USER_W-1:0] s_tuser,   // func[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // reachable[0], zero fill above
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller
  elwr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  elwr_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
